[rtl/core/assert_macros.svh]
// Assertion macros for the RTL of the point transform.
// Depends on nothing; the including module must have clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Overlapping implication, checked on every rising edge out of reset.
`define QRPT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent given as a sequence, so a fixed delay may lead it.
`define QRPT_ASSERT_SEQ(lbl, ante, seq, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> seq) \
    else $error(msg);

`endif

[rtl/core/qrpt_pkg.sv]
// Package for the quaternion rigid point transform: widths, register
// indexes, command codes and pipeline latency. Depends on nothing.
package qrpt_pkg;

  localparam int PointWidthDef = 32;
  localparam int QuatWidthDef  = 16;

  localparam int CfgIdxWidth = 3;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgQuatW  = 3'd0,
    CfgQuatX  = 3'd1,
    CfgQuatY  = 3'd2,
    CfgQuatZ  = 3'd3,
    CfgShiftX = 3'd4,
    CfgShiftY = 3'd5,
    CfgShiftZ = 3'd6
  } cfg_idx_e;

  typedef enum logic {
    CmdPosition = 1'b0,
    CmdExtent   = 1'b1
  } cmd_e;

  // Edges from the accepting edge to the edge that takes the result.
  localparam int Latency = 6;

endpackage

[rtl/core/quaternion_rigid_point_transform.sv]
// Quaternion rotation of a Q16.16 point with translate or absolute value.
// Depends on qrpt_pkg and assert_macros.svh.
//
// The block takes one item per clock cycle, every cycle, with no gaps: busy_o
// stays low. Each item runs through a six-stage pipeline (cross-product
// multiplies, rounding, second multiply bank, sum, add and round, then
// translate or absolute value with saturation), so its result shows on the
// result ports with done_o high for one cycle, once the item has passed the
// last stage. Results leave in the order items came in and
// the receiver cannot stall them. Configuration registers are written through
// cfg_we_i/cfg_idx_i/cfg_wdata_i and must only change while no item is in
// flight; an index beyond the list is ignored.
`include "assert_macros.svh"

module quaternion_rigid_point_transform import qrpt_pkg::*; #(
  parameter int POINT_WIDTH = PointWidthDef,
  parameter int QUAT_WIDTH  = QuatWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          command_i,
  input  logic signed [POINT_WIDTH-1:0] vec_x_i,
  input  logic signed [POINT_WIDTH-1:0] vec_y_i,
  input  logic signed [POINT_WIDTH-1:0] vec_z_i,
  input  logic                          cfg_we_i,
  input  logic [CfgIdxWidth-1:0]        cfg_idx_i,
  input  logic [(POINT_WIDTH > QUAT_WIDTH ? POINT_WIDTH : QUAT_WIDTH)-1:0] cfg_wdata_i,
  output logic                          done_o,
  output logic signed [POINT_WIDTH-1:0] res_x_o,
  output logic signed [POINT_WIDTH-1:0] res_y_o,
  output logic signed [POINT_WIDTH-1:0] res_z_o,
  output logic                          saturated_o
);

  localparam int PW  = POINT_WIDTH;
  localparam int QW  = QUAT_WIDTH;
  localparam int QF  = QW - 2;       // fraction bits of the quaternion
  localparam int P1W = PW + QW;      // first product bank
  localparam int D1W = P1W + 1;      // cross-product difference
  localparam int CW  = D1W - QF;     // rounded cross product
  localparam int P2W = QW + CW;      // second product bank
  localparam int TW  = P2W + 2;      // sum of three products
  localparam int RW  = TW - QF + 1;  // 2*t rounded back to the point format
  localparam int XW  = RW + 1;       // v plus rotation term
  localparam int FW  = XW + 1;       // after translation or absolute value

  localparam logic signed [D1W-1:0] RndC = D1W'(1) <<< (QF - 1);
  localparam logic signed [TW-1:0]  RndT = TW'(1) <<< (QF - 2);

  // Configuration registers
  logic signed [QW-1:0] quat_w_q, quat_x_q, quat_y_q, quat_z_q;
  logic signed [PW-1:0] shift_x_q, shift_y_q, shift_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quat_w_q  <= QW'(1) <<< QF;
      quat_x_q  <= '0;
      quat_y_q  <= '0;
      quat_z_q  <= '0;
      shift_x_q <= '0;
      shift_y_q <= '0;
      shift_z_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgQuatW:  quat_w_q  <= cfg_wdata_i[QW-1:0];
        CfgQuatX:  quat_x_q  <= cfg_wdata_i[QW-1:0];
        CfgQuatY:  quat_y_q  <= cfg_wdata_i[QW-1:0];
        CfgQuatZ:  quat_z_q  <= cfg_wdata_i[QW-1:0];
        CfgShiftX: shift_x_q <= cfg_wdata_i[PW-1:0];
        CfgShiftY: shift_y_q <= cfg_wdata_i[PW-1:0];
        CfgShiftZ: shift_z_q <= cfg_wdata_i[PW-1:0];
        default: ;
      endcase
    end
  end

  logic signed [QW-1:0] u [3];
  logic signed [PW-1:0] s [3];
  logic signed [PW-1:0] vin [3];

  assign u[0]   = quat_x_q;
  assign u[1]   = quat_y_q;
  assign u[2]   = quat_z_q;
  assign s[0]   = shift_x_q;
  assign s[1]   = shift_y_q;
  assign s[2]   = shift_z_q;
  assign vin[0] = vec_x_i;
  assign vin[1] = vec_y_i;
  assign vin[2] = vec_z_i;

  // The pipeline never stalls
  assign busy_o = 1'b0;

  // Pipeline registers, one array element per axis
  logic signed [P1W-1:0] pa_d [3], pa_q [3], pb_d [3], pb_q [3];
  logic signed [CW-1:0]  c_d [3], c_q [3];
  logic signed [P2W-1:0] pw_d [3], pw_q [3], pa2_d [3], pa2_q [3], pb2_d [3], pb2_q [3];
  logic signed [TW-1:0]  t_d [3], t_q [3];
  logic signed [XW-1:0]  x_d [3], x_q [3];
  logic signed [PW-1:0]  res_d [3], res_q [3];
  logic [2:0]            clip_d;
  logic                  sat_q;
  logic signed [PW-1:0]  v1_q [3], v2_q [3], v3_q [3], v4_q [3];
  logic [5:1]            cmd_q;
  logic [6:1]            vld_q;

  for (genvar g = 0; g < 3; g++) begin : g_axis
    localparam int J = (g == 2) ? 0 : g + 1;
    localparam int K = (g == 0) ? 2 : g - 1;

    logic signed [D1W-1:0] diff;
    logic signed [D1W-1:0] diff_rnd;
    logic signed [TW-1:0]  t_rnd;
    logic signed [FW-1:0]  f;
    logic                  over;
    logic                  under;

    // Stage 1: u x v products
    assign pa_d[g] = P1W'(u[J]) * P1W'(vin[K]);
    assign pb_d[g] = P1W'(u[K]) * P1W'(vin[J]);

    // Stage 2: difference, round to the point format
    assign diff     = D1W'(pa_q[g]) - D1W'(pb_q[g]);
    assign diff_rnd = diff + RndC;
    assign c_d[g]   = $signed(diff_rnd[D1W-1:QF]);

    // Stage 3: w*c and u x c products
    assign pw_d[g]  = P2W'(quat_w_q) * P2W'(c_q[g]);
    assign pa2_d[g] = P2W'(u[J]) * P2W'(c_q[K]);
    assign pb2_d[g] = P2W'(u[K]) * P2W'(c_q[J]);

    // Stage 4: sum of the three terms
    assign t_d[g] = TW'(pw_q[g]) + TW'(pa2_q[g]) - TW'(pb2_q[g]);

    // Stage 5: round 2*t in one step and add to v
    assign t_rnd  = t_q[g] + RndT;
    assign x_d[g] = XW'(v4_q[g]) + XW'($signed(t_rnd[TW-1:QF-1]));

    // Stage 6: translate or fold, then clip to the point range
    always_comb begin
      if (cmd_e'(cmd_q[5]) == CmdExtent) begin
        f = x_q[g][XW-1] ? -FW'(x_q[g]) : FW'(x_q[g]);
      end else begin
        f = FW'(x_q[g]) + FW'(s[g]);
      end
    end

    assign over  = !f[FW-1] && (|f[FW-2:PW-1]);
    assign under = f[FW-1] && !(&f[FW-2:PW-1]);

    always_comb begin
      if (over) begin
        res_d[g] = {1'b0, {(PW-1){1'b1}}};
      end else if (under) begin
        res_d[g] = {1'b1, {(PW-1){1'b0}}};
      end else begin
        res_d[g] = f[PW-1:0];
      end
    end

    assign clip_d[g] = over | under;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[5:1], start_i & ~busy_o};
    end
  end

  // Payload advances every cycle; valid bits mark which stages hold an item
  always_ff @(posedge clk_i) begin
    cmd_q <= {cmd_q[4:1], command_i};
    pa_q  <= pa_d;
    pb_q  <= pb_d;
    v1_q  <= vin;
    c_q   <= c_d;
    v2_q  <= v1_q;
    pw_q  <= pw_d;
    pa2_q <= pa2_d;
    pb2_q <= pb2_d;
    v3_q  <= v2_q;
    t_q   <= t_d;
    v4_q  <= v3_q;
    x_q   <= x_d;
    res_q <= res_d;
    sat_q <= |clip_d;
  end

  assign done_o      = vld_q[6];
  assign res_x_o     = res_q[0];
  assign res_y_o     = res_q[1];
  assign res_z_o     = res_q[2];
  assign saturated_o = sat_q;

  `QRPT_ASSERT_SEQ(a_done_follows_start, start_i && !busy_o, ##Latency done_o, "item lost in pipeline")
  `QRPT_ASSERT_IMPL(a_done_has_start, done_o, $past(start_i, Latency), "result without an item")
  `QRPT_ASSERT_IMPL(a_extent_nonneg, done_o && $past(command_i, Latency), !res_x_o[PW-1] && !res_y_o[PW-1] && !res_z_o[PW-1], "negative extent")

endmodule

[test/tb_top.sv]
// Testbench for quaternion_rigid_point_transform: directed and random points
// through a range of poses, each result checked against a local predictor.
// Depends on qrpt_pkg and the block's RTL.
module tb_top;
  import qrpt_pkg::*;

  localparam int Pw        = PointWidthDef;
  localparam int Qw        = QuatWidthDef;
  localparam int QuatFrac  = Qw - 2;
  localparam int IdleLimit = 500;

  localparam logic [CfgIdxWidth-1:0] CfgIdxSpare = 3'd7;

  localparam longint PointMax = (longint'(1) << (Pw - 1)) - 1;
  localparam longint PointMin = -PointMax - 1;

  localparam logic signed [Pw-1:0] CoordMax = {1'b0, {(Pw-1){1'b1}}};
  localparam logic signed [Pw-1:0] CoordMin = {1'b1, {(Pw-1){1'b0}}};
  localparam logic signed [Qw-1:0] QuatOne  = 16'sd16384;
  localparam logic signed [Qw-1:0] QuatHalf = 16'sd11585;

  typedef struct packed {
    logic signed [Pw-1:0] res_x;
    logic signed [Pw-1:0] res_y;
    logic signed [Pw-1:0] res_z;
    logic                 saturated;
  } point_res_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 start_i     = 1'b0;
  logic                 command_i   = 1'b0;
  logic signed [Pw-1:0] vec_x_i     = '0;
  logic signed [Pw-1:0] vec_y_i     = '0;
  logic signed [Pw-1:0] vec_z_i     = '0;
  logic                 cfg_we_i    = 1'b0;
  logic [CfgIdxWidth-1:0] cfg_idx_i = '0;
  logic [Pw-1:0]        cfg_wdata_i = '0;
  logic                 busy_o;
  logic                 done_o;
  logic signed [Pw-1:0] res_x_o;
  logic signed [Pw-1:0] res_y_o;
  logic signed [Pw-1:0] res_z_o;
  logic                 saturated_o;

  // local copy of the pose registers, reset values
  logic signed [Qw-1:0] pose_w = QuatOne;
  logic signed [Qw-1:0] pose_x = '0;
  logic signed [Qw-1:0] pose_y = '0;
  logic signed [Qw-1:0] pose_z = '0;
  logic signed [Pw-1:0] pose_sx = '0;
  logic signed [Pw-1:0] pose_sy = '0;
  logic signed [Pw-1:0] pose_sz = '0;

  point_res_t expected_points[$];
  int mismatch_cnt = 0;
  int idle_cycles  = 0;

  always #4 clk_i = ~clk_i;

  quaternion_rigid_point_transform i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .command_i  (command_i),
    .vec_x_i    (vec_x_i),
    .vec_y_i    (vec_y_i),
    .vec_z_i    (vec_z_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .done_o     (done_o),
    .res_x_o    (res_x_o),
    .res_y_o    (res_y_o),
    .res_z_o    (res_z_o),
    .saturated_o(saturated_o)
  );

  // round to nearest, ties toward plus infinity
  function automatic longint round_shift(longint val, int sh);
    return (val + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  function automatic point_res_t transform_point(cmd_e cmd, logic signed [Pw-1:0] vx,
                                                 logic signed [Pw-1:0] vy,
                                                 logic signed [Pw-1:0] vz);
    longint v [3];
    longint u [3];
    longint c [3];
    longint t [3];
    longint s [3];
    longint w;
    longint acc;
    logic signed [Pw-1:0] out [3];
    point_res_t r;
    w = pose_w;
    u[0] = pose_x;  u[1] = pose_y;  u[2] = pose_z;
    v[0] = vx;      v[1] = vy;      v[2] = vz;
    s[0] = pose_sx; s[1] = pose_sy; s[2] = pose_sz;
    r.saturated = 1'b0;
    c[0] = round_shift(u[1] * v[2] - u[2] * v[1], QuatFrac);
    c[1] = round_shift(u[2] * v[0] - u[0] * v[2], QuatFrac);
    c[2] = round_shift(u[0] * v[1] - u[1] * v[0], QuatFrac);
    t[0] = w * c[0] + (u[1] * c[2] - u[2] * c[1]);
    t[1] = w * c[1] + (u[2] * c[0] - u[0] * c[2]);
    t[2] = w * c[2] + (u[0] * c[1] - u[1] * c[0]);
    for (int k = 0; k < 3; k++) begin
      // doubling folds into the rounding shift
      acc = v[k] + round_shift(t[k], QuatFrac - 1);
      if (cmd == CmdExtent) begin
        acc = (acc < 0) ? -acc : acc;
      end else begin
        acc = acc + s[k];
      end
      if (acc > PointMax) begin
        acc = PointMax;
        r.saturated = 1'b1;
      end else if (acc < PointMin) begin
        acc = PointMin;
        r.saturated = 1'b1;
      end
      out[k] = acc[Pw-1:0];
    end
    r.res_x = out[0];
    r.res_y = out[1];
    r.res_z = out[2];
    return r;
  endfunction

  task automatic note_mismatch(string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) begin
      $display("%0t: %s", $realtime, msg);
    end
  endtask

  always @(posedge clk_i) begin : check_results
    point_res_t want;
    if (rst_ni && done_o) begin
      if (expected_points.size() == 0) begin
        note_mismatch($sformatf("unexpected result x=%0d y=%0d z=%0d sat=%0b",
                                res_x_o, res_y_o, res_z_o, saturated_o));
      end else begin
        want = expected_points.pop_front();
        if (res_x_o !== want.res_x || res_y_o !== want.res_y ||
            res_z_o !== want.res_z || saturated_o !== want.saturated) begin
          note_mismatch($sformatf(
            "exp x=%0d y=%0d z=%0d sat=%0b, got x=%0d y=%0d z=%0d sat=%0b",
            want.res_x, want.res_y, want.res_z, want.saturated,
            res_x_o, res_y_o, res_z_o, saturated_o));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o || cfg_we_i) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Caller stands at a rising edge; returns at the edge that took the item.
  task automatic send_point(cmd_e cmd, logic signed [Pw-1:0] vx, logic signed [Pw-1:0] vy,
                            logic signed [Pw-1:0] vz, int gap_max);
    int gap;
    gap = $urandom_range(gap_max, 0);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i   <= 1'b1;
    command_i <= cmd;
    vec_x_i   <= vx;
    vec_y_i   <= vy;
    vec_z_i   <= vz;
    do @(posedge clk_i); while (busy_o);
    expected_points.insert(expected_points.size(), transform_point(cmd, vx, vy, vz));
  endtask

  task automatic drain_points();
    start_i <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxWidth-1:0] idx, logic [Pw-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      CfgQuatW:  pose_w  = data[Qw-1:0];
      CfgQuatX:  pose_x  = data[Qw-1:0];
      CfgQuatY:  pose_y  = data[Qw-1:0];
      CfgQuatZ:  pose_z  = data[Qw-1:0];
      CfgShiftX: pose_sx = data;
      CfgShiftY: pose_sy = data;
      CfgShiftZ: pose_sz = data;
      default: ;
    endcase
  endtask

  // Block must be idle. Upper bits of quaternion writes carry noise.
  task automatic load_pose(logic signed [Qw-1:0] w, logic signed [Qw-1:0] x,
                           logic signed [Qw-1:0] y, logic signed [Qw-1:0] z,
                           logic signed [Pw-1:0] sx, logic signed [Pw-1:0] sy,
                           logic signed [Pw-1:0] sz);
    write_reg(CfgQuatW, {16'($urandom), w});
    write_reg(CfgQuatX, {16'($urandom), x});
    write_reg(CfgQuatY, {16'($urandom), y});
    write_reg(CfgQuatZ, {16'($urandom), z});
    write_reg(CfgShiftX, sx);
    write_reg(CfgShiftY, sy);
    write_reg(CfgShiftZ, sz);
    write_reg(CfgIdxSpare, $urandom);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic signed [Pw-1:0] rand_coord();
    logic signed [Pw-1:0] raw;
    raw = $urandom;
    case ($urandom_range(9, 0))
      0: return raw;
      1: begin
        case ($urandom_range(3, 0))
          0: return CoordMax;
          1: return CoordMin;
          2: return '0;
          default: return -1;
        endcase
      end
      default: return raw >>> $urandom_range(30, 4);
    endcase
  endfunction

  function automatic logic signed [Qw-1:0] quat_edge();
    case ($urandom_range(4, 0))
      0: return QuatOne;
      1: return -QuatOne;
      2: return '0;
      3: return 16'sh8000;
      default: return 16'sh7fff;
    endcase
  endfunction

  function automatic int rand_quat_part();
    return int'($urandom_range(32768, 0)) - 16384;
  endfunction

  task automatic random_pose();
    real a, b, c, d, n;
    logic signed [Qw-1:0] q [4];
    case ($urandom_range(4, 0))
      3: begin
        for (int k = 0; k < 4; k++) q[k] = 16'(rand_quat_part());
      end
      4: begin
        for (int k = 0; k < 4; k++) q[k] = quat_edge();
      end
      default: begin
        // unit quaternion, normalized in real arithmetic
        a = rand_quat_part();
        b = rand_quat_part();
        c = rand_quat_part();
        d = rand_quat_part();
        n = $sqrt(a * a + b * b + c * c + d * d);
        if (n < 1.0) begin
          a = 1.0;
          n = 1.0;
        end
        q[0] = 16'($rtoi(a / n * 16384.0));
        q[1] = 16'($rtoi(b / n * 16384.0));
        q[2] = 16'($rtoi(c / n * 16384.0));
        q[3] = 16'($rtoi(d / n * 16384.0));
      end
    endcase
    load_pose(q[0], q[1], q[2], q[3], rand_coord(), rand_coord(), rand_coord());
  endtask

  // Reset pose: identity, no translation; extent of the most negative clips.
  task automatic test_passthrough();
    send_point(CmdPosition, '0, '0, '0, 0);
    send_point(CmdPosition, CoordMax, CoordMax, CoordMax, 0);
    send_point(CmdPosition, CoordMin, CoordMin, CoordMin, 0);
    send_point(CmdExtent, CoordMin, CoordMax, -1, 0);
    send_point(CmdExtent, -1, -65536, 1, 3);
    send_point(CmdPosition, 32'sh55555555, 32'shaaaaaaaa, 32'sh0000ffff, 0);
    drain_points();
  endtask

  task automatic test_fixed_rotations();
    // quarter turn about z
    load_pose(QuatHalf, '0, '0, QuatHalf, 32'sh00018000, -32'sh00020000, '0);
    send_point(CmdPosition, 32'sh00010000, '0, '0, 0);
    send_point(CmdPosition, '0, 32'sh00010000, '0, 0);
    send_point(CmdExtent, 32'sh00010000, -32'sh00020000, 3, 5);
    drain_points();
    // half turn about x, largest translation: clip high
    load_pose('0, QuatOne, '0, '0, CoordMax, CoordMax, CoordMax);
    send_point(CmdPosition, CoordMax, CoordMax, CoordMax, 0);
    send_point(CmdPosition, CoordMin, 32'sh12345678, -32'sh12345678, 0);
    drain_points();
    // negated identity, smallest translation: clip low
    load_pose(-QuatOne, '0, '0, '0, CoordMin, CoordMin, CoordMin);
    send_point(CmdPosition, CoordMin, CoordMin, CoordMin, 0);
    send_point(CmdExtent, CoordMin, '0, '0, 0);
    drain_points();
    // raw codes outside the unit range
    load_pose(16'sh8000, 16'sh7fff, QuatOne, -QuatOne, 32'sh7fff0000, '0, CoordMin);
    send_point(CmdPosition, CoordMax, CoordMin, 32'sd12345, 0);
    send_point(CmdExtent, 32'sh00400000, -32'sh00400000, 32'sh7fffffff, 2);
    send_point(CmdPosition, CoordMin, CoordMin, CoordMin, 0);
    drain_points();
    load_pose(QuatOne, QuatOne, QuatOne, QuatOne, '0, '0, '0);
    send_point(CmdPosition, 32'sh00010000, 32'sh00020000, -32'sh00030000, 0);
    drain_points();
    load_pose(-QuatOne, -QuatOne, -QuatOne, -QuatOne, -1, 1, '0);
    send_point(CmdExtent, CoordMax, -32'sh00010000, CoordMin, 0);
    drain_points();
  endtask

  task automatic test_random_poses();
    int gap_max;
    for (int phase = 0; phase < 10; phase++) begin
      random_pose();
      gap_max = (phase % 3 == 0) ? 0 : 17;
      for (int n = 0; n < 83; n++) begin
        // hold off once mid-phase until the pipeline is empty
        if (phase == 4 && n == 40) drain_points();
        send_point(cmd_e'($urandom_range(1, 0)), rand_coord(), rand_coord(), rand_coord(),
                   gap_max);
      end
      drain_points();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_passthrough();
    test_fixed_rotations();
    test_random_poses();
    drain_points();
    repeat (Latency + 2) @(posedge clk_i);
    if (mismatch_cnt == 0 && expected_points.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
